// ===== src/lda_pkg.sv =====
// ----------------------------------------------------------------------------
// lda_pkg
// constants, types and helpers for the lda collapsed gibbs token sampler
// ----------------------------------------------------------------------------
package lda_pkg;

  localparam int WORD_BITS  = 10;
  localparam int DOC_BITS   = 8;
  localparam int TOPIC_BITS = 4;
  localparam int MAX_TOPICS = 1 << TOPIC_BITS;
  localparam int COUNT_W    = 16;
  localparam int TOTAL_W    = 24;
  localparam int FACTOR_W   = COUNT_W + 9;
  localparam int PROD_W     = 2 * FACTOR_W;
  localparam int DEN_W      = 33;
  localparam int WEIGHT_W   = 32;
  localparam int SUM_W      = WEIGHT_W + TOPIC_BITS;
  localparam int WT_ABITS   = WORD_BITS + TOPIC_BITS;
  localparam int DT_ABITS   = DOC_BITS + TOPIC_BITS;
  localparam int WT_DEPTH   = 1 << WT_ABITS;
  localparam int DT_DEPTH   = 1 << DT_ABITS;
  localparam int DIV_CNT_W  = 5;

  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_BETA   = 2'd1;
  localparam logic [1:0] REG_VOCAB  = 2'd2;
  localparam logic [1:0] REG_TOPICS = 2'd3;

  localparam logic CMD_ADD = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_W_RD,
    ST_W_FAC,
    ST_W_MUL,
    ST_W_DIVI,
    ST_W_DIV,
    ST_W_ACC,
    ST_THR,
    ST_SCAN,
    ST_ADD_RD,
    ST_ADD_WR
  } lda_state_t;

  function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] v);
    cnt_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_W-1:0] cnt_dec(input logic [COUNT_W-1:0] v);
    cnt_dec = (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] tot_inc(input logic [TOTAL_W-1:0] v);
    tot_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] tot_dec(input logic [TOTAL_W-1:0] v);
    tot_dec = (v == '0) ? v : v - 1'b1;
  endfunction

endpackage

// ===== src/lda_collapsed_gibbs_token_sampler.sv =====
// ----------------------------------------------------------------------------
// lda_collapsed_gibbs_token_sampler
// count tables and per-token topic sampling for collapsed gibbs lda
// ----------------------------------------------------------------------------
// usage: a token arrives on the in_ valid/ready channel with a command,
// document, word, current topic and random fraction. an add transaction
// counts the token under its topic and returns that topic. a resample
// transaction removes the token, weighs every topic in use, picks one
// against the random fraction, counts it back and returns the new topic.
// one transaction is processed at a time. a resample runs the 32-step serial
// divider once per topic in use, skipped only where the quotient saturates.
// the result sits in an output register on out_; a new transaction is
// accepted while it waits, but the final count update holds until the
// receiver takes the previous result.
// after reset the word-topic and doc-topic memories are swept to zero, one
// entry a cycle, while in_ready stays low; configuration writes on cfg_ are
// taken at any time and should be made only when idle.
// ----------------------------------------------------------------------------
module lda_collapsed_gibbs_token_sampler
  import lda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [DOC_BITS-1:0]   in_doc_id,
  input  logic [WORD_BITS-1:0]  in_word_id,
  input  logic [TOPIC_BITS-1:0] in_old_topic,
  input  logic [15:0]           in_random_fraction,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOPIC_BITS-1:0] out_new_topic
);

  lda_state_t state_r, state_nxt;

  logic [15:0] alpha_r, beta_r;
  logic [10:0] vocab_r;
  logic [4:0]  topics_r;

  logic [COUNT_W-1:0] wt_mem [WT_DEPTH];
  logic [COUNT_W-1:0] dt_mem [DT_DEPTH];
  logic [COUNT_W-1:0] wt_q, dt_q;
  logic               mem_we;
  logic [WT_ABITS-1:0] wt_addr;
  logic [DT_ABITS-1:0] dt_addr;
  logic [COUNT_W-1:0]  wt_wd, dt_wd;

  logic [TOTAL_W-1:0] totals_r [MAX_TOPICS];
  logic [SUM_W-1:0]   cum_r [MAX_TOPICS];

  logic [WT_ABITS-1:0]   clr_r;
  logic [DOC_BITS-1:0]   doc_r;
  logic [WORD_BITS-1:0]  word_r;
  logic [TOPIC_BITS-1:0] topic_r, k_r, last_r;
  logic [15:0]           rand_r;
  logic [FACTOR_W-1:0]   wf_r, df_r;
  logic [DEN_W-1:0]      den_r;
  logic [PROD_W-1:0]     prod_r;
  logic [DEN_W:0]        rem_r;
  logic [WEIGHT_W-1:0]   shf_r, quot_r;
  logic [DIV_CNT_W-1:0]  bit_r;
  logic [SUM_W-1:0]      sum_r, thr_r;
  logic                  out_valid_r;
  logic [TOPIC_BITS-1:0] out_topic_r;

  logic [4:0]            kk;
  logic [TOPIC_BITS-1:0] last_in, t_sat;
  logic [TOPIC_BITS-1:0] mem_topic, tot_idx;
  logic [TOTAL_W-1:0]    tot_rd;
  logic [DEN_W:0]        trial;
  logic [SUM_W+15:0]     thr_full;
  logic                  in_fire;

  // topic count limits
  always_comb begin
    if (topics_r == 5'd0) begin
      kk = 5'd1;
    end else if (topics_r > 5'(MAX_TOPICS)) begin
      kk = 5'(MAX_TOPICS);
    end else begin
      kk = topics_r;
    end
    last_in = TOPIC_BITS'(kk - 5'd1);
    t_sat   = ({1'b0, in_old_topic} >= kk) ? last_in : in_old_topic;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_new_topic = out_topic_r;

  assign tot_idx  = (state_r == ST_W_FAC) ? k_r : topic_r;
  assign tot_rd   = totals_r[tot_idx];
  assign trial    = {rem_r[DEN_W-1:0], shf_r[WEIGHT_W-1]};
  assign thr_full = sum_r * rand_r;

  // next state and memory control
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_topic = topic_r;
    wt_wd     = '0;
    dt_wd     = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_r == WT_ABITS'(WT_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_command == CMD_ADD) ? ST_ADD_RD : ST_DEC_RD;
        end
      end
      ST_DEC_RD: state_nxt = ST_DEC_WR;
      ST_DEC_WR: begin
        mem_we    = 1'b1;
        wt_wd     = cnt_dec(wt_q);
        dt_wd     = cnt_dec(dt_q);
        state_nxt = ST_W_RD;
      end
      ST_W_RD: begin
        mem_topic = k_r;
        state_nxt = ST_W_FAC;
      end
      ST_W_FAC:  state_nxt = ST_W_MUL;
      ST_W_MUL:  state_nxt = ST_W_DIVI;
      ST_W_DIVI: begin
        state_nxt = ({8'd0, prod_r[PROD_W-1:24]} >= den_r) ? ST_W_ACC : ST_W_DIV;
      end
      ST_W_DIV: begin
        if (bit_r == '0) begin
          state_nxt = ST_W_ACC;
        end
      end
      ST_W_ACC:  state_nxt = (k_r == last_r) ? ST_THR : ST_W_RD;
      ST_THR:    state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (cum_r[k_r] > thr_r || k_r == last_r) begin
          state_nxt = ST_ADD_RD;
        end
      end
      ST_ADD_RD: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        mem_we    = 1'b1;
        wt_wd     = cnt_inc(wt_q);
        dt_wd     = cnt_inc(dt_q);
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_CLEAR) begin
      wt_addr = clr_r;
      dt_addr = clr_r[DT_ABITS-1:0];
    end else begin
      wt_addr = {word_r, mem_topic};
      dt_addr = {doc_r, mem_topic};
    end
  end

  // count memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wt_mem[wt_addr] <= wt_wd;
      dt_mem[dt_addr] <= dt_wd;
    end
    wt_q <= wt_mem[wt_addr];
    dt_q <= dt_mem[dt_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      alpha_r     <= 16'd256;
      beta_r      <= 16'd26;
      vocab_r     <= 11'd1024;
      topics_r    <= 5'd16;
      for (int i = 0; i < MAX_TOPICS; i++) begin
        totals_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHA:  alpha_r  <= cfg_wdata;
          REG_BETA:   beta_r   <= cfg_wdata;
          REG_VOCAB:  vocab_r  <= cfg_wdata[10:0];
          REG_TOPICS: topics_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (state_r == ST_DEC_WR) begin
        totals_r[topic_r] <= tot_dec(tot_rd);
      end
      if (state_r == ST_ADD_WR) begin
        totals_r[topic_r] <= tot_inc(tot_rd);
        out_valid_r       <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        doc_r   <= in_doc_id;
        word_r  <= in_word_id;
        topic_r <= t_sat;
        rand_r  <= in_random_fraction;
        last_r  <= last_in;
      end
      ST_DEC_WR: begin
        k_r   <= '0;
        sum_r <= '0;
      end
      ST_W_FAC: begin
        wf_r <= {1'b0, wt_q, 8'd0} + FACTOR_W'(beta_r);
        df_r <= {1'b0, dt_q, 8'd0} + FACTOR_W'(alpha_r);
        if (tot_rd == '0 && (vocab_r == '0 || beta_r == '0)) begin
          den_r <= DEN_W'(1);
        end else begin
          den_r <= {1'b0, tot_rd, 8'd0} + DEN_W'(vocab_r * beta_r);
        end
      end
      ST_W_MUL: prod_r <= wf_r * df_r;
      ST_W_DIVI: begin
        quot_r <= {WEIGHT_W{1'b1}};
        rem_r  <= {8'd0, prod_r[PROD_W-1:24]};
        shf_r  <= {prod_r[23:0], 8'd0};
        bit_r  <= DIV_CNT_W'(WEIGHT_W - 1);
      end
      ST_W_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_r  <= trial - {1'b0, den_r};
          quot_r <= {quot_r[WEIGHT_W-2:0], 1'b1};
        end else begin
          rem_r  <= trial;
          quot_r <= {quot_r[WEIGHT_W-2:0], 1'b0};
        end
        shf_r <= {shf_r[WEIGHT_W-2:0], 1'b0};
        bit_r <= bit_r - 1'b1;
      end
      ST_W_ACC: begin
        sum_r      <= sum_r + SUM_W'(quot_r);
        cum_r[k_r] <= sum_r + SUM_W'(quot_r);
        k_r        <= k_r + 1'b1;
      end
      ST_THR: begin
        thr_r <= thr_full[SUM_W+15:16];
        k_r   <= '0;
      end
      ST_SCAN: begin
        if (cum_r[k_r] > thr_r || k_r == last_r) begin
          topic_r <= k_r;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      ST_ADD_WR: out_topic_r <= topic_r;
      default: ;
    endcase
  end

endmodule
